// File: hw/rtl/bspm_pkg.sv
// Package for the buffer slot pool manager: command and slot condition codes,
// widths, and the control structs passed between the sequencer, store and compare unit.
// No dependencies.
`timescale 1ns / 1ps

package bspm_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int IDX_W      = 3;
   localparam int COUNT_W    = 4;
   localparam int STAMP_W    = 32;
   localparam int CMD_W      = 3;
   localparam int COND_W     = 2;

   localparam logic [CMD_W-1:0] CMD_ALLOC       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_COMMIT      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TAKE_OLDEST = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TAKE_NEWEST = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RELEASE     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_PURGE_ALL   = 3'd5;

   localparam logic [COND_W-1:0] COND_EMPTY  = 2'd0;
   localparam logic [COND_W-1:0] COND_FILLED = 2'd1;
   localparam logic [COND_W-1:0] COND_LOCKED = 2'd2;

   localparam logic [STAMP_W-1:0] STAMP_TOP = 32'hffff_ffff;

   // write request into the slot store
   typedef struct packed {
      logic                en;
      logic [IDX_W-1:0]    index;
      logic [COND_W-1:0]   cond;
      logic                stamp_en;
      logic [STAMP_W-1:0]  stamp;
   } store_wr_type;

   // control of the shared compare unit
   typedef struct packed {
      logic init;        // restart search
      logic init_top;    // start value all ones (oldest) or zero (newest)
      logic step;        // evaluate the slot on the read port
      logic want_newest; // keep the larger stamp instead of the smaller
   } cmp_ctl_type;

endpackage

// File: hw/rtl/bspm_slot_store.sv
// Slot store: condition and stamp of every slot, one read address, one write port.
// Depends on bspm_pkg.
`timescale 1ns / 1ps

module bspm_slot_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bspm_pkg::IDX_W-1:0]    rd_index,
   input  bspm_pkg::store_wr_type        wr,
   output logic [bspm_pkg::COND_W-1:0]   rd_cond,
   output logic [bspm_pkg::STAMP_W-1:0]  rd_stamp
);

   logic [bspm_pkg::COND_W-1:0]  cond_ff  [bspm_pkg::SLOT_COUNT];
   logic [bspm_pkg::STAMP_W-1:0] stamp_ff [bspm_pkg::SLOT_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bspm_pkg::SLOT_COUNT; i++) begin
            cond_ff[i] <= bspm_pkg::COND_EMPTY;
         end
      end else if (wr.en) begin
         cond_ff[wr.index] <= wr.cond;
      end
   end

   // stamps only matter once a slot is filled, and filling always writes one
   always_ff @(posedge clock) begin
      if (wr.en && wr.stamp_en) begin
         stamp_ff[wr.index] <= wr.stamp;
      end
   end

   assign rd_cond  = cond_ff[rd_index];
   assign rd_stamp = stamp_ff[rd_index];

endmodule

// File: hw/rtl/bspm_cmp_unit.sv
// Shared stamp compare unit: tracks the best filled slot over a scan.
// Depends on bspm_pkg.
`timescale 1ns / 1ps

module bspm_cmp_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  bspm_pkg::cmp_ctl_type         ctl,
   input  logic [bspm_pkg::COND_W-1:0]   rd_cond,
   input  logic [bspm_pkg::STAMP_W-1:0]  rd_stamp,
   input  logic [bspm_pkg::IDX_W-1:0]    rd_index,
   output logic [bspm_pkg::IDX_W-1:0]    best_index,
   output logic                          found
);

   logic [bspm_pkg::IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [bspm_pkg::STAMP_W-1:0] best_ts_ff,  best_ts_in;
   logic                         found_ff,    found_in;
   logic [bspm_pkg::STAMP_W-1:0] op_a, op_b;
   logic                         better;

   // one magnitude comparator; operands swap for the newest search
   assign op_a   = ctl.want_newest ? best_ts_ff : rd_stamp;
   assign op_b   = ctl.want_newest ? rd_stamp   : best_ts_ff;
   assign better = (op_a < op_b);

   always_comb begin
      best_idx_in = best_idx_ff;
      best_ts_in  = best_ts_ff;
      found_in    = found_ff;
      if (ctl.init) begin
         best_idx_in = '0;
         best_ts_in  = ctl.init_top ? bspm_pkg::STAMP_TOP : '0;
         found_in    = 1'b0;
      end else if (ctl.step && (rd_cond == bspm_pkg::COND_FILLED) && better) begin
         best_idx_in = rd_index;
         best_ts_in  = rd_stamp;
         found_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_ts_ff  <= best_ts_in;
   end

   assign best_index = best_idx_ff;
   assign found      = found_ff;

endmodule

// File: hw/rtl/buffer_slot_pool_manager.sv
// Top level of the buffer slot pool manager: request sequencer, CSR port, result register.
// Depends on bspm_pkg, bspm_slot_store and bspm_cmp_unit.
`timescale 1ns / 1ps

// Keeps a pool of up to eight buffer slots (empty, filled or locked, each with a
// 32-bit stamp). One request is handled at a time; req_stall is high from the
// transfer until the sequencer is back in idle. The sequencer walks the slots one
// per cycle through a single store read port and one shared stamp comparator, so
// the cost is set by that scan: commit and release touch one slot, unused commands
// none, purge-all clears and take-oldest/newest reads every active slot, allocate
// tries a remembered released slot, then stops at the first empty slot. The result
// sits in an output register, so the next request is taken while a result still
// waits; a request only stalls at its end if the previous result is still held.
// Register 0 (byte address 0), active_slots: values 0 act as 1, above 8 as 8.
module buffer_slot_pool_manager (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bspm_pkg::CMD_W-1:0]          req_cmd,
   input  logic [bspm_pkg::IDX_W-1:0]          req_slot_index,
   input  logic [bspm_pkg::STAMP_W-1:0]        req_stamp,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_status,
   output logic [bspm_pkg::IDX_W-1:0]          rsp_slot_out,
   output logic                                rsp_evicted,
   // CSR port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [2:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RECENT = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_FINAL  = 3'd3;
   localparam logic [2:0] S_UPDATE = 3'd4;
   localparam logic [2:0] S_PURGE  = 3'd5;
   localparam logic [2:0] S_POST   = 3'd6;

   localparam int IW = bspm_pkg::IDX_W;
   localparam int CW = bspm_pkg::COUNT_W;

   logic [2:0]                    state_ff, state_in;
   logic [bspm_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [IW-1:0]                 idx_ff, idx_in;
   logic [bspm_pkg::STAMP_W-1:0]  stamp_ff, stamp_in;
   logic [IW-1:0]                 scan_ff, scan_in;
   logic                          recent_valid_ff, recent_valid_in;
   logic [IW-1:0]                 recent_index_ff, recent_index_in;
   logic [CW-1:0]                 active_ff, active_in;
   logic                          res_status_ff, res_status_in;
   logic [IW-1:0]                 res_slot_ff, res_slot_in;
   logic                          res_evicted_ff, res_evicted_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_status_ff;
   logic [IW-1:0]                 rsp_slot_ff;
   logic                          rsp_evicted_ff;

   logic [CW-1:0]                 live;
   logic [CW-1:0]                 live_last;
   logic                          scan_done;
   logic                          req_xfer;
   logic                          rsp_load;
   logic                          csr_wr;
   logic [IW-1:0]                 rd_index;
   logic [bspm_pkg::COND_W-1:0]   rd_cond;
   logic [bspm_pkg::STAMP_W-1:0]  rd_stamp;
   bspm_pkg::store_wr_type        wr;
   bspm_pkg::cmp_ctl_type         cmp_ctl;
   logic [IW-1:0]                 best_index;
   logic                          found;

   // ---------------------------------------------------------------- CSR
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign prdata = (paddr[2] == 1'b0) ? {{(32-CW){1'b0}}, active_ff} : '0;
   assign active_in = csr_wr ? pwdata[CW-1:0] : active_ff;

   // effective slot count, clamped to 1..SLOT_COUNT
   always_comb begin
      if (active_ff == '0) begin
         live = CW'(1);
      end else if (active_ff > CW'(bspm_pkg::SLOT_COUNT)) begin
         live = CW'(bspm_pkg::SLOT_COUNT);
      end else begin
         live = active_ff;
      end
   end
   assign live_last = live - CW'(1);
   assign scan_done = ({1'b0, scan_ff} == live_last);

   // ---------------------------------------------------------------- handshake
   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == S_POST) && (!rsp_valid_ff || !rsp_stall);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      idx_in          = idx_ff;
      stamp_in        = stamp_ff;
      scan_in         = scan_ff;
      recent_valid_in = recent_valid_ff;
      recent_index_in = recent_index_ff;
      res_status_in   = res_status_ff;
      res_slot_in     = res_slot_ff;
      res_evicted_in  = res_evicted_ff;
      rd_index        = scan_ff;
      wr              = '0;
      cmp_ctl         = '0;
      cmp_ctl.want_newest = (cmd_ff == bspm_pkg::CMD_TAKE_NEWEST);

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in           = req_cmd;
               idx_in           = req_slot_index;
               stamp_in         = req_stamp;
               scan_in          = '0;
               res_status_in    = 1'b0;
               res_slot_in      = '0;
               res_evicted_in   = 1'b0;
               cmp_ctl.init     = 1'b1;
               cmp_ctl.init_top = (req_cmd != bspm_pkg::CMD_TAKE_NEWEST);
               unique case (req_cmd) inside
                  bspm_pkg::CMD_ALLOC:
                     state_in = recent_valid_ff ? S_RECENT : S_SCAN;
                  bspm_pkg::CMD_COMMIT, bspm_pkg::CMD_RELEASE:
                     state_in = S_UPDATE;
                  bspm_pkg::CMD_TAKE_OLDEST, bspm_pkg::CMD_TAKE_NEWEST:
                     state_in = S_SCAN;
                  bspm_pkg::CMD_PURGE_ALL:
                     state_in = S_PURGE;
                  default:
                     state_in = S_POST;
               endcase
            end
         end

         // remembered slot wins if still empty and in range; memory is dropped
         S_RECENT: begin
            rd_index        = recent_index_ff;
            recent_valid_in = 1'b0;
            if (({1'b0, recent_index_ff} < live) && (rd_cond == bspm_pkg::COND_EMPTY)) begin
               res_slot_in = recent_index_ff;
               state_in    = S_POST;
            end else begin
               state_in = S_SCAN;
            end
         end

         // one slot per cycle; allocate stops at the first empty slot
         S_SCAN: begin
            rd_index = scan_ff;
            if ((cmd_ff == bspm_pkg::CMD_ALLOC) && (rd_cond == bspm_pkg::COND_EMPTY)) begin
               res_slot_in = scan_ff;
               state_in    = S_POST;
            end else begin
               cmp_ctl.step = 1'b1;
               if (scan_done) begin
                  state_in = S_FINAL;
               end else begin
                  scan_in = scan_ff + IW'(1);
               end
            end
         end

         // act on the chosen slot
         S_FINAL: begin
            rd_index = best_index;
            wr.index = best_index;
            if (cmd_ff == bspm_pkg::CMD_ALLOC) begin
               if (rd_cond == bspm_pkg::COND_LOCKED) begin
                  res_status_in = 1'b1;
               end else begin
                  wr.en          = 1'b1;
                  wr.cond        = bspm_pkg::COND_EMPTY;
                  res_slot_in    = best_index;
                  res_evicted_in = 1'b1;
               end
            end else if (!found) begin
               res_status_in = 1'b1;
            end else begin
               wr.en       = 1'b1;
               wr.cond     = bspm_pkg::COND_LOCKED;
               res_slot_in = best_index;
            end
            state_in = S_POST;
         end

         // commit or release of one slot
         S_UPDATE: begin
            rd_index = idx_ff;
            wr.index = idx_ff;
            if ({1'b0, idx_ff} >= live) begin
               res_status_in = 1'b1;
            end else if (cmd_ff == bspm_pkg::CMD_COMMIT) begin
               wr.en       = 1'b1;
               wr.cond     = bspm_pkg::COND_FILLED;
               wr.stamp_en = 1'b1;
               wr.stamp    = stamp_ff;
            end else begin
               wr.en           = 1'b1;
               wr.cond         = bspm_pkg::COND_EMPTY;
               recent_valid_in = 1'b1;
               recent_index_in = idx_ff;
            end
            state_in = S_POST;
         end

         // clear active slots one per cycle
         S_PURGE: begin
            wr.en    = 1'b1;
            wr.index = scan_ff;
            wr.cond  = bspm_pkg::COND_EMPTY;
            if (scan_done) begin
               state_in = S_POST;
            end else begin
               scan_in = scan_ff + IW'(1);
            end
         end

         // wait for the result register to free up
         S_POST: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         recent_valid_ff <= 1'b0;
         recent_index_ff <= '0;
         active_ff       <= CW'(bspm_pkg::SLOT_COUNT);
         rsp_valid_ff    <= 1'b0;
         scan_ff         <= '0;
         cmd_ff          <= bspm_pkg::CMD_ALLOC;
      end else begin
         state_ff        <= state_in;
         recent_valid_ff <= recent_valid_in;
         recent_index_ff <= recent_index_in;
         active_ff       <= active_in;
         rsp_valid_ff    <= rsp_valid_in;
         scan_ff         <= scan_in;
         cmd_ff          <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      stamp_ff       <= stamp_in;
      res_status_ff  <= res_status_in;
      res_slot_ff    <= res_slot_in;
      res_evicted_ff <= res_evicted_in;
      if (rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_slot_ff    <= res_slot_ff;
         rsp_evicted_ff <= res_evicted_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_evicted  = rsp_evicted_ff;

   // ---------------------------------------------------------------- datapath
   bspm_slot_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_index (rd_index),
      .wr       (wr),
      .rd_cond  (rd_cond),
      .rd_stamp (rd_stamp)
   );

   bspm_cmp_unit u_cmp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (cmp_ctl),
      .rd_cond    (rd_cond),
      .rd_stamp   (rd_stamp),
      .rd_index   (rd_index),
      .best_index (best_index),
      .found      (found)
   );

endmodule

// File: bench/bspm_checker.sv
// Checker for the buffer slot pool manager: tracks slot state from observed request
// and CSR transfers, predicts each result and compares it with the result channel.
// Depends on bspm_pkg.
`timescale 1ns / 1ps

module bspm_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [bspm_pkg::CMD_W-1:0]    req_cmd,
   input  logic [bspm_pkg::IDX_W-1:0]    req_slot_index,
   input  logic [bspm_pkg::STAMP_W-1:0]  req_stamp,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_status,
   input  logic [bspm_pkg::IDX_W-1:0]    rsp_slot_out,
   input  logic                          rsp_evicted,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic                          pready,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output int                            errors,
   output int                            pending
);
   import bspm_pkg::*;

   localparam logic [2:0] REG_ACTIVE_SLOTS = 3'd0;

   typedef struct packed {
      logic             status;
      logic [IDX_W-1:0] slot;
      logic             evicted;
   } slot_answer_type;

   logic [COND_W-1:0]  pool_cond  [SLOT_COUNT];
   logic [STAMP_W-1:0] pool_stamp [SLOT_COUNT];
   logic               recent_valid;
   logic [IDX_W-1:0]   recent_idx;
   logic [COUNT_W-1:0] active_slots;
   slot_answer_type    answers_due [$];
   int                 mismatch_count = 0;
   int                 waiting = 0;

   assign errors  = mismatch_count;
   assign pending = waiting;

   // register value 0 acts as 1, anything above the pool size as the pool size
   function automatic int live_slots();
      int n;
      n = int'(active_slots);
      if (n == 0) n = 1;
      if (n > SLOT_COUNT) n = SLOT_COUNT;
      return n;
   endfunction

   function automatic void clear_slot(int i);
      pool_cond[i]  = COND_EMPTY;
      pool_stamp[i] = '0;
   endfunction

   function automatic slot_answer_type serve_request(logic [CMD_W-1:0] cmd,
                                                     logic [IDX_W-1:0] idx,
                                                     logic [STAMP_W-1:0] stmp);
      slot_answer_type    res;
      int                 n;
      int                 best;
      int                 i;
      logic [STAMP_W-1:0] ts;
      bit                 found;
      bit                 oldest;
      res    = '0;
      n      = live_slots();
      best   = 0;
      found  = 1'b0;
      oldest = (cmd == CMD_TAKE_OLDEST);
      case (cmd)
         CMD_ALLOC: begin
            ts = STAMP_TOP;
            // remembered slot is consumed by any allocate
            if (recent_valid) begin
               recent_valid = 1'b0;
               if (int'(recent_idx) < n && pool_cond[recent_idx] == COND_EMPTY) begin
                  res.slot = recent_idx;
                  found    = 1'b1;
               end
            end
            for (i = 0; i < n && !found; i++) begin
               if (pool_cond[i] == COND_EMPTY) begin
                  res.slot = i[IDX_W-1:0];
                  found    = 1'b1;
               end else if (pool_cond[i] == COND_FILLED && pool_stamp[i] < ts) begin
                  best = i;
                  ts   = pool_stamp[i];
               end
            end
            if (!found) begin
               if (pool_cond[best] == COND_LOCKED) begin
                  res.status = 1'b1;
               end else begin
                  clear_slot(best);
                  res.slot    = best[IDX_W-1:0];
                  res.evicted = 1'b1;
               end
            end
         end
         CMD_COMMIT, CMD_RELEASE: begin
            if (int'(idx) >= n) begin
               res.status = 1'b1;
            end else if (cmd == CMD_COMMIT) begin
               pool_cond[idx]  = COND_FILLED;
               pool_stamp[idx] = stmp;
            end else begin
               clear_slot(int'(idx));
               recent_valid = 1'b1;
               recent_idx   = idx;
            end
         end
         CMD_TAKE_OLDEST, CMD_TAKE_NEWEST: begin
            ts = oldest ? STAMP_TOP : '0;
            for (i = 0; i < n; i++) begin
               if (pool_cond[i] == COND_FILLED &&
                   (oldest ? pool_stamp[i] < ts : pool_stamp[i] > ts)) begin
                  best  = i;
                  ts    = pool_stamp[i];
                  found = 1'b1;
               end
            end
            if (found) begin
               pool_cond[best] = COND_LOCKED;
               res.slot        = best[IDX_W-1:0];
            end else begin
               res.status = 1'b1;
            end
         end
         CMD_PURGE_ALL: begin
            for (i = 0; i < n; i++) clear_slot(i);
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : watch
      slot_answer_type got;
      slot_answer_type want;
      int              i;
      if (reset) begin
         for (i = 0; i < SLOT_COUNT; i++) clear_slot(i);
         recent_valid = 1'b0;
         recent_idx   = '0;
         active_slots = SLOT_COUNT[COUNT_W-1:0];
         answers_due.delete();
      end else begin
         // result side first: a result never belongs to a request taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_slot_out, rsp_evicted};
            if (answers_due.size() == 0) begin
               $display("%0t: expected no result, got status=%0d slot=%0d evicted=%0d",
                        $time, got.status, got.slot, got.evicted);
               mismatch_count++;
            end else begin
               want = answers_due.pop_front();
               if (got !== want) begin
                  $display("%0t: status/slot/evicted expected %0d/%0d/%0d got %0d/%0d/%0d",
                           $time, want.status, want.slot, want.evicted,
                           got.status, got.slot, got.evicted);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            answers_due.push_back(serve_request(req_cmd, req_slot_index, req_stamp));
         if (psel && penable && pwrite && pready && paddr == REG_ACTIVE_SLOTS)
            active_slots = pwdata[COUNT_W-1:0];
      end
      waiting = answers_due.size();
   end

endmodule

// File: bench/tb_buffer_slot_pool_manager.sv
// Testbench top for the buffer slot pool manager: clock, reset, request/result/CSR
// stimulus, watchdog and verdict. Checking is done by bspm_checker.
// Depends on bspm_pkg, bspm_checker and buffer_slot_pool_manager.
`timescale 1ns / 1ps

module tb_buffer_slot_pool_manager;
   import bspm_pkg::*;

   localparam int SETTLE_CYCLES = 16;    // covers the longest request, n <= 8
   localparam int QUIET_LIMIT   = 4000;  // cycles without any transfer before giving up
   localparam int HOLD_CYCLES   = 200;   // long result hold-off
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 205;

   localparam logic [2:0]       REG_ACTIVE_SLOTS = 3'd0;
   // command codes the block ignores
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [CMD_W-1:0]   req_cmd;
   logic [IDX_W-1:0]   req_slot_index;
   logic [STAMP_W-1:0] req_stamp;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_status;
   logic [IDX_W-1:0]   rsp_slot_out;
   logic               rsp_evicted;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   int chk_errors;
   int chk_pending;

   int send_idle_pct;   // chance per cycle that the request side holds back
   int recv_stall_pct;  // chance per cycle that the result side stalls
   int hold_asks = 0;   // bumped by the stimulus to ask for a long hold-off
   int eff_slots;       // effective slot count, used to aim slot indexes
   int items_sent = 0;
   int quiet_cycles = 0;

   buffer_slot_pool_manager dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_slot_index (req_slot_index),
      .req_stamp      (req_stamp),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_evicted    (rsp_evicted),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   bspm_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_slot_index (req_slot_index),
      .req_stamp      (req_stamp),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_evicted    (rsp_evicted),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .errors         (chk_errors),
      .pending        (chk_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result side: random stalls at the current rate. A bump of hold_asks starts a
   // long hold-off, counted here, so the block fills its output register and then
   // backs up the request side while the sender keeps offering.
   initial begin : result_side
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   // Watchdog: any request or result transfer restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One request transfer. Random idle cycles go in front; the payload then stays
   // put until the edge that takes it. Valid stays high into the next call, so
   // back-to-back transfers keep it up.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                            input logic [STAMP_W-1:0] stmp);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_cmd        = cmd;
      req_slot_index = idx;
      req_stamp      = stmp;
      req_valid      = 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      items_sent++;
   endtask

   // Mostly slots inside the active range, some anywhere; stamps lean on the
   // extremes and on a few small values so that ties come up often.
   task automatic send_random();
      int                 pick;
      logic [CMD_W-1:0]   cmd;
      logic [IDX_W-1:0]   idx;
      logic [STAMP_W-1:0] stmp;
      pick = $urandom_range(0, 99);
      if (pick < 26)      cmd = CMD_ALLOC;
      else if (pick < 56) cmd = CMD_COMMIT;
      else if (pick < 68) cmd = CMD_TAKE_OLDEST;
      else if (pick < 80) cmd = CMD_TAKE_NEWEST;
      else if (pick < 94) cmd = CMD_RELEASE;
      else if (pick < 97) cmd = CMD_PURGE_ALL;
      else                cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
      if ($urandom_range(0, 9) == 0) idx = IDX_W'($urandom_range(0, SLOT_COUNT - 1));
      else                           idx = IDX_W'($urandom_range(0, eff_slots - 1));
      pick = $urandom_range(0, 9);
      if (pick == 0)      stmp = '0;
      else if (pick == 1) stmp = STAMP_TOP;
      else if (pick < 5)  stmp = $urandom_range(0, 7);
      else if (pick == 5) stmp = STAMP_TOP - $urandom_range(0, 3);
      else                stmp = $urandom;
      send_item(cmd, idx, stmp);
   endtask

   // Drop valid, wait for every outstanding result, then let the sequencer settle.
   task automatic quiesce();
      @(negedge clock);
      req_valid = 1'b0;
      while (chk_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // CSR write: setup cycle, then access cycle (pready is always high).
   task automatic write_active_slots(input logic [COUNT_W-1:0] val);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = REG_ACTIVE_SLOTS;
      pwdata  = {{(32 - COUNT_W){1'b0}}, val};
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      eff_slots = (val == 0) ? 1 : (int'(val) > SLOT_COUNT ? SLOT_COUNT : int'(val));
   endtask

   // Slot-count settings of the random phases, extremes and out-of-range values included.
   function automatic logic [COUNT_W-1:0] phase_slots(int p);
      case (p)
         0:       return 4'd1;
         1:       return 4'd8;
         2:       return 4'd3;
         3:       return 4'd0;
         4:       return 4'd15;
         default: return 4'd5;
      endcase
   endfunction

   initial begin : stimulus
      int p;
      int k;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_ALLOC;
      req_slot_index = '0;
      req_stamp      = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = REG_ACTIVE_SLOTS;
      pwdata         = '0;
      send_idle_pct  = 8;
      recv_stall_pct = 59;
      eff_slots      = SLOT_COUNT;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, full pool after reset: takes on an empty pool are refused,
      // stamp extremes, lock by oldest and newest, remembered slot reuse,
      // purge-all and the ignored command codes.
      send_item(CMD_TAKE_OLDEST, 3'd0, '0);
      send_item(CMD_TAKE_NEWEST, 3'd7, STAMP_TOP);
      send_item(CMD_ALLOC,       3'd0, '0);
      send_item(CMD_COMMIT,      3'd0, STAMP_TOP);
      send_item(CMD_COMMIT,      3'd1, '0);
      send_item(CMD_TAKE_OLDEST, 3'd0, '0);   // stamp 0 is the only one below top
      send_item(CMD_TAKE_NEWEST, 3'd0, '0);   // only the all-ones stamp is above 0
      send_item(CMD_RELEASE,     3'd1, '0);
      send_item(CMD_ALLOC,       3'd0, '0);   // hands back the released slot
      send_item(CMD_PURGE_ALL,   3'd0, '0);
      send_item(CMD_SPARE_6,     3'd0, '0);
      send_item(CMD_SPARE_7,     3'd7, STAMP_TOP);
      send_item(CMD_COMMIT,      3'd7, 32'd5);
      send_item(CMD_RELEASE,     3'd7, '0);
      send_item(CMD_ALLOC,       3'd0, '0);   // remembered slot at the top index

      // Two slots: eviction with tied stamps, eviction falling back to slot 0
      // when every stamp is all ones, a locked candidate, out-of-range slots.
      quiesce();
      write_active_slots(4'd2);
      send_item(CMD_COMMIT,      3'd0, 32'd10);
      send_item(CMD_COMMIT,      3'd1, 32'd10);
      send_item(CMD_ALLOC,       3'd0, '0);
      send_item(CMD_COMMIT,      3'd0, STAMP_TOP);
      send_item(CMD_COMMIT,      3'd1, STAMP_TOP);
      send_item(CMD_ALLOC,       3'd0, '0);
      send_item(CMD_COMMIT,      3'd0, STAMP_TOP);
      send_item(CMD_TAKE_NEWEST, 3'd0, '0);
      send_item(CMD_TAKE_NEWEST, 3'd0, '0);
      send_item(CMD_ALLOC,       3'd0, '0);   // candidate locked: none available
      send_item(CMD_COMMIT,      3'd5, 32'hdead_beef);
      send_item(CMD_RELEASE,     3'd2, '0);
      send_item(CMD_RELEASE,     3'd1, '0);

      // Remembered slot now beyond the active range.
      quiesce();
      write_active_slots(4'd1);
      send_item(CMD_ALLOC,       3'd0, '0);

      // Random phases: first the request side idles rarely and the result side
      // often, then the reverse, then no idling at all.
      for (p = 0; p < PHASES; p++) begin
         quiesce();
         write_active_slots(phase_slots(p));
         if (p < 2) begin
            send_idle_pct  = 8;
            recv_stall_pct = 59;
         end else if (p < 4) begin
            send_idle_pct  = 59;
            recv_stall_pct = 8;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         for (k = 0; k < PHASE_ITEMS; k++) begin
            send_random();
            if (p == 1 && k == 20) hold_asks++;
         end
      end

      quiesce();
      $display("Covered %0d requests: directed corner cases and %0d random phases",
               items_sent, PHASES);
      $display("over slot counts 0..15, a long result hold-off and full drains between phases.");
      if (chk_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/bspm_pkg.sv
hw/rtl/bspm_slot_store.sv
hw/rtl/bspm_cmp_unit.sv
hw/rtl/buffer_slot_pool_manager.sv
bench/bspm_checker.sv
bench/tb_buffer_slot_pool_manager.sv
